// File: design/nhqp_pkg.sv
// Package: shared types, constants and helpers for the NVMe host queue pair engine.
`timescale 1ns / 1ps
`default_nettype none
package nhqp_pkg;

   // Ring geometry
   localparam int ADMIN_DEPTH = 8;
   localparam int IO_DEPTH    = 128;
   localparam int ADMIN_IDX_W = (ADMIN_DEPTH > 2) ? $clog2(ADMIN_DEPTH) : 1;
   localparam int IO_IDX_W    = (IO_DEPTH > 2) ? $clog2(IO_DEPTH) : 1;
   localparam int DB_VAL_W    = (ADMIN_IDX_W > IO_IDX_W) ? ADMIN_IDX_W : IO_IDX_W;

   // Fixed field widths
   localparam int SLOT_W      = 7;
   localparam int CID_W       = 16;
   localparam int DBOFF_W     = 19;
   localparam int STRIDE_W    = 4;
   localparam int BEAT_W      = 5;

   localparam logic [DBOFF_W-1:0] DOORBELL_BASE = 19'h01000;
   localparam logic [CID_W-1:0]   IO_NAMESPACE  = 16'h0001;

   // Item kinds
   localparam logic ITEM_SUBMIT     = 1'b0;
   localparam logic ITEM_COMPLETION = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_ENTRY    = 2'd0;
   localparam logic [1:0] KIND_DOORBELL = 2'd1;
   localparam logic [1:0] KIND_REPORT   = 2'd2;

   // Completion states
   localparam logic [1:0] CPL_PENDING = 2'd0;
   localparam logic [1:0] CPL_SUCCESS = 2'd1;
   localparam logic [1:0] CPL_ERROR   = 2'd2;

   // Beat of the tail doorbell after the 16 entry dwords
   localparam logic [BEAT_W-1:0] BEAT_TAIL_DB = 5'd16;

   // Work descriptor handed from front to back
   typedef struct packed {
      logic                is_cpl;
      logic                queue;
      logic [SLOT_W-1:0]   slot;
      logic [CID_W-1:0]    cid;
      logic [7:0]          opcode;
      logic [31:0]         dw1;
      logic [63:0]         addr;
      logic [31:0]         dw10;
      logic [31:0]         dw11;
      logic [31:0]         dw12;
      logic [31:0]         dw13;
      logic [DB_VAL_W-1:0] db_val;
      logic [DBOFF_W-1:0]  db_offset;
      logic [1:0]          cstate;
   } desc_type;

   function automatic logic [DBOFF_W-1:0] doorbell_at(input logic q, input logic is_cq,
                                                      input logic [STRIDE_W-1:0] exp);
      logic [4:0] sh;
      sh = 5'd2 + 5'(exp);
      return DOORBELL_BASE + (DBOFF_W'({q, is_cq}) << sh);
   endfunction

endpackage
`default_nettype wire

// File: design/nhqp_front.sv
// Front end: accepts transactions, owns ring state and builds work descriptors.
`timescale 1ns / 1ps
`default_nettype none
module nhqp_front
   import nhqp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                item_kind,
   input  wire logic                queue_id,
   input  wire logic [7:0]          cmd_opcode,
   input  wire logic [31:0]         namespace_id,
   input  wire logic [31:0]         cmd_dword10,
   input  wire logic [31:0]         cmd_dword11,
   input  wire logic [31:0]         cmd_dword12,
   input  wire logic [31:0]         cmd_dword13,
   input  wire logic [63:0]         data_addr,
   input  wire logic [63:0]         start_lba,
   input  wire logic [15:0]         block_count,
   input  wire logic [15:0]         cqe_status,
   input  wire logic [STRIDE_W-1:0] stride_exp,
   output desc_type                 desc
);

   logic [ADMIN_IDX_W-1:0] admin_tail_ff, admin_tail_in;
   logic [ADMIN_IDX_W-1:0] admin_head_ff, admin_head_in;
   logic                   admin_phase_ff, admin_phase_in;
   logic [IO_IDX_W-1:0]    io_tail_ff, io_tail_in;
   logic [IO_IDX_W-1:0]    io_head_ff, io_head_in;
   logic                   io_phase_ff, io_phase_in;
   logic [CID_W-1:0]       cid_ff, cid_in;

   logic [ADMIN_IDX_W-1:0] admin_tail_nx, admin_head_nx;
   logic [IO_IDX_W-1:0]    io_tail_nx, io_head_nx;
   logic                   phase;
   logic                   cpl_ok;

   assign admin_tail_nx = (admin_tail_ff == ADMIN_IDX_W'(ADMIN_DEPTH - 1)) ? '0
                        : admin_tail_ff + 1'b1;
   assign admin_head_nx = (admin_head_ff == ADMIN_IDX_W'(ADMIN_DEPTH - 1)) ? '0
                        : admin_head_ff + 1'b1;
   assign io_tail_nx    = (io_tail_ff == IO_IDX_W'(IO_DEPTH - 1)) ? '0 : io_tail_ff + 1'b1;
   assign io_head_nx    = (io_head_ff == IO_IDX_W'(IO_DEPTH - 1)) ? '0 : io_head_ff + 1'b1;

   assign phase  = queue_id ? io_phase_ff : admin_phase_ff;
   assign cpl_ok = (cqe_status[0] == phase) && (cqe_status[15:1] == 15'd0);

   always_comb begin
      admin_tail_in  = admin_tail_ff;
      admin_head_in  = admin_head_ff;
      admin_phase_in = admin_phase_ff;
      io_tail_in     = io_tail_ff;
      io_head_in     = io_head_ff;
      io_phase_in    = io_phase_ff;
      cid_in         = cid_ff;
      if (accept) begin
         if (item_kind == ITEM_SUBMIT) begin
            cid_in = cid_ff + 1'b1;
            if (queue_id) begin
               io_tail_in = io_tail_nx;
            end else begin
               admin_tail_in = admin_tail_nx;
            end
         end else if (cpl_ok) begin
            if (queue_id) begin
               io_head_in = io_head_nx;
               if (io_head_nx == '0) begin
                  io_phase_in = ~io_phase_ff;
               end
            end else begin
               admin_head_in = admin_head_nx;
               if (admin_head_nx == '0) begin
                  admin_phase_in = ~admin_phase_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         admin_tail_ff  <= '0;
         admin_head_ff  <= '0;
         admin_phase_ff <= 1'b1;
         io_tail_ff     <= '0;
         io_head_ff     <= '0;
         io_phase_ff    <= 1'b1;
         cid_ff         <= '0;
      end else begin
         admin_tail_ff  <= admin_tail_in;
         admin_head_ff  <= admin_head_in;
         admin_phase_ff <= admin_phase_in;
         io_tail_ff     <= io_tail_in;
         io_head_ff     <= io_head_in;
         io_phase_ff    <= io_phase_in;
         cid_ff         <= cid_in;
      end
   end

   // Descriptor for the transaction presented this cycle
   always_comb begin
      desc        = '0;
      desc.is_cpl = item_kind;
      desc.queue  = queue_id;
      desc.opcode = cmd_opcode;
      desc.addr   = data_addr;
      if (item_kind == ITEM_SUBMIT) begin
         desc.cid       = cid_ff + 1'b1;
         desc.db_offset = doorbell_at(queue_id, 1'b0, stride_exp);
         if (queue_id) begin
            desc.slot   = SLOT_W'(io_tail_ff);
            desc.db_val = DB_VAL_W'(io_tail_nx);
            desc.dw1    = 32'(IO_NAMESPACE);
            desc.dw10   = start_lba[31:0];
            desc.dw11   = start_lba[63:32];
            desc.dw12   = 32'(block_count);
            desc.dw13   = 32'd0;
         end else begin
            desc.slot   = SLOT_W'(admin_tail_ff);
            desc.db_val = DB_VAL_W'(admin_tail_nx);
            desc.dw1    = namespace_id;
            desc.dw10   = cmd_dword10;
            desc.dw11   = cmd_dword11;
            desc.dw12   = cmd_dword12;
            desc.dw13   = cmd_dword13;
         end
      end else begin
         desc.db_offset = doorbell_at(queue_id, 1'b1, stride_exp);
         if (queue_id) begin
            desc.slot   = SLOT_W'(io_head_ff);
            desc.db_val = DB_VAL_W'(io_head_nx);
         end else begin
            desc.slot   = SLOT_W'(admin_head_ff);
            desc.db_val = DB_VAL_W'(admin_head_nx);
         end
         if (cqe_status[0] != phase) begin
            desc.cstate = CPL_PENDING;
         end else if (cqe_status[15:1] != 15'd0) begin
            desc.cstate = CPL_ERROR;
         end else begin
            desc.cstate = CPL_SUCCESS;
         end
      end
   end

endmodule
`default_nettype wire

// File: design/nhqp_queue.sv
// Two-entry descriptor queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module nhqp_queue
   import nhqp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_desc,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output desc_type      head_desc
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

// File: design/nhqp_back.sv
// Back end: sequences each descriptor into result beats through an output register.
`timescale 1ns / 1ps
`default_nettype none
module nhqp_back
   import nhqp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_not_empty,
   input  wire desc_type      q_desc,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [1:0]         rsp_out_kind,
   output logic               rsp_out_queue,
   output logic [SLOT_W-1:0]  rsp_slot_index,
   output logic [3:0]         rsp_dword_index,
   output logic [31:0]        rsp_write_data,
   output logic [DBOFF_W-1:0] rsp_doorbell_offset,
   output logic [CID_W-1:0]   rsp_command_id,
   output logic [1:0]         rsp_completion_state,
   output logic               rsp_last
);

   logic [BEAT_W-1:0]  beat_ff, beat_in;
   logic               valid_ff, valid_in;
   logic [1:0]         kind_ff, kind_in;
   logic               queue_ff, queue_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [3:0]         dw_ff, dw_in;
   logic [31:0]        data_ff, data_in;
   logic [DBOFF_W-1:0] dboff_ff, dboff_in;
   logic [CID_W-1:0]   cid_ff, cid_in;
   logic [1:0]         cstate_ff, cstate_in;
   logic               last_ff, last_in;

   logic               load;
   logic [31:0]        entry_dw;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      case (beat_ff[3:0])
         4'd0:    entry_dw = {q_desc.cid, 8'h00, q_desc.opcode};
         4'd1:    entry_dw = q_desc.dw1;
         4'd6:    entry_dw = q_desc.addr[31:0];
         4'd7:    entry_dw = q_desc.addr[63:32];
         4'd10:   entry_dw = q_desc.dw10;
         4'd11:   entry_dw = q_desc.dw11;
         4'd12:   entry_dw = q_desc.dw12;
         4'd13:   entry_dw = q_desc.dw13;
         default: entry_dw = 32'd0;
      endcase
   end

   always_comb begin
      beat_in   = beat_ff;
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      queue_in  = queue_ff;
      slot_in   = slot_ff;
      dw_in     = dw_ff;
      data_in   = data_ff;
      dboff_in  = dboff_ff;
      cid_in    = cid_ff;
      cstate_in = cstate_ff;
      last_in   = last_ff;
      q_pop     = 1'b0;
      if (load) begin
         valid_in  = q_not_empty;
         queue_in  = q_desc.queue;
         slot_in   = q_desc.slot;
         dw_in     = 4'd0;
         data_in   = 32'd0;
         dboff_in  = '0;
         cid_in    = '0;
         cstate_in = CPL_PENDING;
         last_in   = 1'b0;
         kind_in   = KIND_REPORT;
         if (!q_desc.is_cpl) begin
            cid_in = q_desc.cid;
            if (beat_ff == BEAT_TAIL_DB) begin
               kind_in  = KIND_DOORBELL;
               data_in  = 32'(q_desc.db_val);
               dboff_in = q_desc.db_offset;
               last_in  = 1'b1;
            end else begin
               kind_in = KIND_ENTRY;
               dw_in   = beat_ff[3:0];
               data_in = entry_dw;
            end
         end else if ((q_desc.cstate == CPL_SUCCESS) && (beat_ff == '0)) begin
            kind_in  = KIND_DOORBELL;
            data_in  = 32'(q_desc.db_val);
            dboff_in = q_desc.db_offset;
         end else begin
            cstate_in = q_desc.cstate;
            last_in   = 1'b1;
         end
         if (q_not_empty) begin
            if (last_in) begin
               q_pop   = 1'b1;
               beat_in = '0;
            end else begin
               beat_in = beat_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      queue_ff  <= queue_in;
      slot_ff   <= slot_in;
      dw_ff     <= dw_in;
      data_ff   <= data_in;
      dboff_ff  <= dboff_in;
      cid_ff    <= cid_in;
      cstate_ff <= cstate_in;
      last_ff   <= last_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_out_kind         = kind_ff;
   assign rsp_out_queue        = queue_ff;
   assign rsp_slot_index       = slot_ff;
   assign rsp_dword_index      = dw_ff;
   assign rsp_write_data       = data_ff;
   assign rsp_doorbell_offset  = dboff_ff;
   assign rsp_command_id       = cid_ff;
   assign rsp_completion_state = cstate_ff;
   assign rsp_last             = last_ff;

endmodule
`default_nettype wire

// File: design/nvme_host_queue_pair_engine_top.sv
// Top level: NVMe host queue pair engine (admin and I/O pairs, phase-tag completion).
`timescale 1ns / 1ps
`default_nettype none
// Host side of two NVMe queue pairs: queue 0 is admin (8 slots), queue 1 is I/O
// (128 slots). A submit transaction takes the next shared command id and yields
// 17 result transactions: the 16 dwords of the 64-byte entry at the tail slot,
// then the tail doorbell write carrying the new tail. A completion transaction
// checks the status halfword of the entry at the head against the expected
// phase and yields one report (pending or error, nothing consumed) or, on
// success, a head doorbell write followed by a success report.
// Rate: the result port moves one transaction per cycle while rsp_stall is low.
// The front end updates ring state and accepts a transaction in the cycle it
// arrives, as long as the two-entry descriptor queue has room; the back-end
// sequencer and its output register set the sustained rate.
// csr_wr_data sets the doorbell stride exponent (spacing 4 << value bytes);
// write it only while the engine is idle. Reset is synchronous and active high.
module nvme_host_queue_pair_engine_top
   import nhqp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // Configuration
   input  wire logic                csr_wr_en,
   input  wire logic [STRIDE_W-1:0] csr_wr_data,
   // Request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_item_kind,
   input  wire logic                req_queue_id,
   input  wire logic [7:0]          req_cmd_opcode,
   input  wire logic [31:0]         req_namespace_id,
   input  wire logic [31:0]         req_cmd_dword10,
   input  wire logic [31:0]         req_cmd_dword11,
   input  wire logic [31:0]         req_cmd_dword12,
   input  wire logic [31:0]         req_cmd_dword13,
   input  wire logic [63:0]         req_data_addr,
   input  wire logic [63:0]         req_start_lba,
   input  wire logic [15:0]         req_block_count,
   input  wire logic [15:0]         req_cqe_status,
   // Response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_out_kind,
   output logic                     rsp_out_queue,
   output logic [SLOT_W-1:0]        rsp_slot_index,
   output logic [3:0]               rsp_dword_index,
   output logic [31:0]              rsp_write_data,
   output logic [DBOFF_W-1:0]       rsp_doorbell_offset,
   output logic [CID_W-1:0]         rsp_command_id,
   output logic [1:0]               rsp_completion_state,
   output logic                     rsp_last
);

   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic                accept;
   logic                q_full;
   logic                q_not_empty;
   logic                q_pop;
   desc_type            front_desc;
   desc_type            head_desc;

   // Doorbell stride register
   assign stride_in = csr_wr_en ? csr_wr_data : stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= '0;
      end else begin
         stride_ff <= stride_in;
      end
   end

   // Accept whenever the descriptor queue has a free entry
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   nhqp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .item_kind    (req_item_kind),
      .queue_id     (req_queue_id),
      .cmd_opcode   (req_cmd_opcode),
      .namespace_id (req_namespace_id),
      .cmd_dword10  (req_cmd_dword10),
      .cmd_dword11  (req_cmd_dword11),
      .cmd_dword12  (req_cmd_dword12),
      .cmd_dword13  (req_cmd_dword13),
      .data_addr    (req_data_addr),
      .start_lba    (req_start_lba),
      .block_count  (req_block_count),
      .cqe_status   (req_cqe_status),
      .stride_exp   (stride_ff),
      .desc         (front_desc)
   );

   nhqp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_desc (front_desc),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_desc (head_desc)
   );

   nhqp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_not_empty          (q_not_empty),
      .q_desc               (head_desc),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_kind         (rsp_out_kind),
      .rsp_out_queue        (rsp_out_queue),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_dword_index      (rsp_dword_index),
      .rsp_write_data       (rsp_write_data),
      .rsp_doorbell_offset  (rsp_doorbell_offset),
      .rsp_command_id       (rsp_command_id),
      .rsp_completion_state (rsp_completion_state),
      .rsp_last             (rsp_last)
   );

endmodule
`default_nettype wire

// File: sim/tb_nvme_host_queue_pair_engine_top.sv
// Self-checking testbench for the NVMe host queue pair engine (admin and I/O rings).
`timescale 1ns / 1ps
module tb_nvme_host_queue_pair_engine_top
   import nhqp_pkg::*;
();

   localparam int SETTLE_CYCLES  = 20;    // quiet time after the last result
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
   localparam int MAX_REPORTS    = 40;    // mismatch lines printed before going quiet

   // One request transaction, one field per port
   typedef struct {
      logic        kind;
      logic        qid;
      logic [7:0]  opcode;
      logic [31:0] nsid;
      logic [31:0] dw10;
      logic [31:0] dw11;
      logic [31:0] dw12;
      logic [31:0] dw13;
      logic [63:0] addr;
      logic [63:0] lba;
      logic [15:0] nblk;
      logic [15:0] status;
   } nvme_item_type;

   // One host-side write or report on the response channel
   typedef struct {
      logic [1:0]         kind;
      logic               queue;
      logic [SLOT_W-1:0]  slot;
      logic [3:0]         dw;
      logic [31:0]        data;
      logic [DBOFF_W-1:0] dboff;
      logic [CID_W-1:0]   cid;
      logic [1:0]         cstate;
      logic               last;
   } host_write_type;

   logic                clock;
   logic                reset                = 1'b1;
   logic                csr_wr_en            = 1'b0;
   logic [STRIDE_W-1:0] csr_wr_data          = '0;
   logic                req_valid            = 1'b0;
   logic                req_stall;
   logic                req_item_kind        = 1'b0;
   logic                req_queue_id         = 1'b0;
   logic [7:0]          req_cmd_opcode       = '0;
   logic [31:0]         req_namespace_id     = '0;
   logic [31:0]         req_cmd_dword10      = '0;
   logic [31:0]         req_cmd_dword11      = '0;
   logic [31:0]         req_cmd_dword12      = '0;
   logic [31:0]         req_cmd_dword13      = '0;
   logic [63:0]         req_data_addr        = '0;
   logic [63:0]         req_start_lba        = '0;
   logic [15:0]         req_block_count      = '0;
   logic [15:0]         req_cqe_status       = '0;
   logic                rsp_valid;
   logic                rsp_stall            = 1'b0;
   logic [1:0]          rsp_out_kind;
   logic                rsp_out_queue;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic [3:0]          rsp_dword_index;
   logic [31:0]         rsp_write_data;
   logic [DBOFF_W-1:0]  rsp_doorbell_offset;
   logic [CID_W-1:0]    rsp_command_id;
   logic [1:0]          rsp_completion_state;
   logic                rsp_last;

   // Ring state tracked alongside the engine
   logic [ADMIN_IDX_W-1:0] trk_adm_tail  = '0;
   logic [ADMIN_IDX_W-1:0] trk_adm_head  = '0;
   logic                   trk_adm_phase = 1'b1;
   logic [IO_IDX_W-1:0]    trk_io_tail   = '0;
   logic [IO_IDX_W-1:0]    trk_io_head   = '0;
   logic                   trk_io_phase  = 1'b1;
   logic [CID_W-1:0]       cid_ctr       = '0;
   logic [STRIDE_W-1:0]    stride_exp    = '0;

   host_write_type host_writes_q[$];
   host_write_type want;
   int             fail_cnt   = 0;
   int             idle_cnt   = 0;
   int             stall_left = 0;
   bit             no_idle    = 1'b0;

   nvme_host_queue_pair_engine_top u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_item_kind        (req_item_kind),
      .req_queue_id         (req_queue_id),
      .req_cmd_opcode       (req_cmd_opcode),
      .req_namespace_id     (req_namespace_id),
      .req_cmd_dword10      (req_cmd_dword10),
      .req_cmd_dword11      (req_cmd_dword11),
      .req_cmd_dword12      (req_cmd_dword12),
      .req_cmd_dword13      (req_cmd_dword13),
      .req_data_addr        (req_data_addr),
      .req_start_lba        (req_start_lba),
      .req_block_count      (req_block_count),
      .req_cqe_status       (req_cqe_status),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_kind         (rsp_out_kind),
      .rsp_out_queue        (rsp_out_queue),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_dword_index      (rsp_dword_index),
      .rsp_write_data       (rsp_write_data),
      .rsp_doorbell_offset  (rsp_doorbell_offset),
      .rsp_command_id       (rsp_command_id),
      .rsp_completion_state (rsp_completion_state),
      .rsp_last             (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int ring_next(input int idx, input int depth);
      return (idx + 1 >= depth) ? 0 : idx + 1;
   endfunction

   // doorbell register: base + (2*queue + is_cq) * (4 << stride)
   function automatic logic [DBOFF_W-1:0] db_offset(input logic q, input logic is_cq);
      logic [31:0] spacing;
      logic [31:0] off;
      spacing = 32'd4 << stride_exp;
      off = 32'(DOORBELL_BASE) + (32'(q) * 32'd2 + 32'(is_cq)) * spacing;
      return off[DBOFF_W-1:0];
   endfunction

   function automatic host_write_type mk_write(input logic [1:0] kind, input logic q,
                                               input int slot, input int dw,
                                               input logic [31:0] data,
                                               input logic [DBOFF_W-1:0] dboff,
                                               input logic [CID_W-1:0] cid,
                                               input logic [1:0] cstate,
                                               input logic last);
      host_write_type w;
      w.kind   = kind;
      w.queue  = q;
      w.slot   = SLOT_W'(slot);
      w.dw     = 4'(dw);
      w.data   = data;
      w.dboff  = dboff;
      w.cid    = cid;
      w.cstate = cstate;
      w.last   = last;
      return w;
   endfunction

   // Advance the tracked rings by one accepted transaction and queue what the
   // engine must write: 16 entry dwords plus tail doorbell, or a head check.
   task automatic compute_host_writes(input nvme_item_type it);
      logic [31:0] sqe [16];
      int          slot;
      int          depth;
      int          nxt;
      logic        phase;
      depth = it.qid ? IO_DEPTH : ADMIN_DEPTH;
      if (it.kind == ITEM_SUBMIT) begin
         slot = it.qid ? int'(trk_io_tail) : int'(trk_adm_tail);
         cid_ctr = cid_ctr + 1'b1;
         foreach (sqe[i]) sqe[i] = '0;
         sqe[0] = {cid_ctr, 8'h00, it.opcode};
         sqe[6] = it.addr[31:0];
         sqe[7] = it.addr[63:32];
         if (it.qid) begin
            sqe[1]  = 32'd1;
            sqe[10] = it.lba[31:0];
            sqe[11] = it.lba[63:32];
            sqe[12] = {16'h0000, it.nblk};
         end else begin
            sqe[1]  = it.nsid;
            sqe[10] = it.dw10;
            sqe[11] = it.dw11;
            sqe[12] = it.dw12;
            sqe[13] = it.dw13;
         end
         for (int i = 0; i < 16; i++)
            host_writes_q.push_back(mk_write(KIND_ENTRY, it.qid, slot, i, sqe[i], '0,
                                             cid_ctr, CPL_PENDING, 1'b0));
         nxt = ring_next(slot, depth);
         if (it.qid) trk_io_tail = IO_IDX_W'(nxt);
         else trk_adm_tail = ADMIN_IDX_W'(nxt);
         host_writes_q.push_back(mk_write(KIND_DOORBELL, it.qid, slot, 0, 32'(nxt),
                                          db_offset(it.qid, 1'b0), cid_ctr,
                                          CPL_PENDING, 1'b1));
      end else begin
         slot  = it.qid ? int'(trk_io_head) : int'(trk_adm_head);
         phase = it.qid ? trk_io_phase : trk_adm_phase;
         if (it.status[0] != phase) begin
            // stale entry: controller has not posted it yet
            host_writes_q.push_back(mk_write(KIND_REPORT, it.qid, slot, 0, '0, '0, '0,
                                             CPL_PENDING, 1'b1));
         end else if (it.status[15:1] != '0) begin
            // error status leaves the entry in place
            host_writes_q.push_back(mk_write(KIND_REPORT, it.qid, slot, 0, '0, '0, '0,
                                             CPL_ERROR, 1'b1));
         end else begin
            nxt = ring_next(slot, depth);
            if (it.qid) begin
               trk_io_head = IO_IDX_W'(nxt);
               if (nxt == 0) trk_io_phase = ~trk_io_phase;
            end else begin
               trk_adm_head = ADMIN_IDX_W'(nxt);
               if (nxt == 0) trk_adm_phase = ~trk_adm_phase;
            end
            host_writes_q.push_back(mk_write(KIND_DOORBELL, it.qid, slot, 0, 32'(nxt),
                                             db_offset(it.qid, 1'b1), '0,
                                             CPL_PENDING, 1'b0));
            host_writes_q.push_back(mk_write(KIND_REPORT, it.qid, slot, 0, '0, '0, '0,
                                             CPL_SUCCESS, 1'b1));
         end
      end
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   // mostly short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(15, 40);
   endfunction

   // Random payload; completion status is mostly a success on the expected phase so
   // that heads advance and wrap, the rest is stale or error status.
   function automatic nvme_item_type rand_item(input int pct_submit, input int pct_io);
      nvme_item_type it;
      logic          phase;
      int            r;
      it.kind   = ($urandom_range(0, 99) < pct_submit) ? ITEM_SUBMIT : ITEM_COMPLETION;
      it.qid    = ($urandom_range(0, 99) < pct_io) ? 1'b1 : 1'b0;
      it.opcode = 8'($urandom);
      it.nsid   = $urandom;
      it.dw10   = $urandom;
      it.dw11   = $urandom;
      it.dw12   = $urandom;
      it.dw13   = $urandom;
      it.addr   = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom};
      it.lba    = {$urandom, $urandom};
      it.nblk   = 16'($urandom);
      phase = it.qid ? trk_io_phase : trk_adm_phase;
      r = $urandom_range(0, 99);
      if (r < 60) it.status = {15'd0, phase};
      else if (r < 80) it.status = {15'($urandom_range(1, 32767)), phase};
      else it.status = {15'($urandom), ~phase};
      return it;
   endfunction

   function automatic nvme_item_type cpl_item(input logic q, input logic [15:0] status);
      nvme_item_type it;
      it = rand_item(0, q ? 100 : 0);
      it.status = status;
      return it;
   endfunction

   function automatic nvme_item_type flat_submit(input logic q, input logic ones);
      nvme_item_type it;
      it = '{default: '0};
      if (ones) it = '{default: '1};
      it.kind = ITEM_SUBMIT;
      it.qid  = q;
      return it;
   endfunction

   // Present one transaction and hold it until accepted. Returns at the
   // accepting edge without touching req_valid, so the caller either sends
   // again or drops valid in that same step.
   task automatic send_item(input nvme_item_type it);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 1) == 1) gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_item_kind    <= it.kind;
      req_queue_id     <= it.qid;
      req_cmd_opcode   <= it.opcode;
      req_namespace_id <= it.nsid;
      req_cmd_dword10  <= it.dw10;
      req_cmd_dword11  <= it.dw11;
      req_cmd_dword12  <= it.dw12;
      req_cmd_dword13  <= it.dw13;
      req_data_addr    <= it.addr;
      req_start_lba    <= it.lba;
      req_block_count  <= it.nblk;
      req_cqe_status   <= it.status;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      compute_host_writes(it);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (host_writes_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stride only changes with the engine drained
   task automatic set_stride(input logic [STRIDE_W-1:0] value);
      wait_all_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      stride_exp = value;
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // Field extremes on both rings, then every completion outcome.
   task automatic test_directed_items();
      set_stride(4'd0);
      send_item(flat_submit(1'b0, 1'b0));
      send_item(flat_submit(1'b0, 1'b1));
      send_item(flat_submit(1'b1, 1'b0));
      send_item(flat_submit(1'b1, 1'b1));
      send_item(cpl_item(1'b0, 16'h0000));   // phase mismatch -> pending
      send_item(cpl_item(1'b0, 16'hFFFF));   // phase ok, all status bits -> error
      send_item(cpl_item(1'b0, 16'h0003));   // lowest status bit -> error
      send_item(cpl_item(1'b0, 16'h0001));   // success
      send_item(cpl_item(1'b1, 16'hFFFE));   // pending
      send_item(cpl_item(1'b1, 16'h8001));   // top status bit -> error
      send_item(cpl_item(1'b1, 16'h0001));   // success
   endtask

   // Widest doorbell spacing: I/O head doorbell lands at the top offset.
   task automatic test_stride_extremes();
      set_stride(4'd15);
      send_item(rand_item(100, 0));
      send_item(rand_item(100, 100));
      send_item(cpl_item(1'b0, {15'd0, trk_adm_phase}));
      send_item(cpl_item(1'b1, {15'd0, trk_io_phase}));
   endtask

   // Drive both rings past their depth so tails/heads wrap and phases flip,
   // and keep going on the flipped phase.
   task automatic test_ring_wrap();
      set_stride(4'($urandom_range(1, 14)));
      for (int i = 0; i < 130; i++) begin
         send_item(rand_item(100, 100));
         send_item(cpl_item(1'b1, {15'd0, trk_io_phase}));
         if (i < 20) begin
            send_item(rand_item(100, 0));
            send_item(cpl_item(1'b0, {15'd0, trk_adm_phase}));
         end
      end
   endtask

   // Mixed traffic in phases at several strides; one phase without idling,
   // one that pauses mid-way until the engine has drained.
   task automatic test_random_traffic();
      logic [STRIDE_W-1:0] strides [4];
      strides = '{4'd15, 4'($urandom), 4'd0, 4'($urandom)};
      for (int ph = 0; ph < 4; ph++) begin
         set_stride(strides[ph]);
         no_idle = (ph == 2);
         for (int n = 0; n < 40; n++) begin
            if (ph == 3 && n == 20) wait_all_results();
            send_item(rand_item(50, 50));
         end
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_items();
      test_stride_extremes();
      test_ring_wrap();
      test_random_traffic();
      wait_all_results();
      if (fail_cnt == 0) begin
         $display("nvme_host_queue_pair_engine_top regression: pass");
      end else begin
         $display("nvme_host_queue_pair_engine_top regression: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------- response side

   // Random backpressure on the result channel, one assignment per edge.
   always @(posedge clock) begin
      if (no_idle) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
         stall_left = idle_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         fail_cnt++;
         if (fail_cnt <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      end
   endtask

   // Compare every accepted result transaction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (host_writes_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
               $error("result with nothing outstanding: kind %0d queue %0d slot %0d",
                      rsp_out_kind, rsp_out_queue, rsp_slot_index);
         end else begin
            want = host_writes_q.pop_front();
            check_field("out_kind", 64'(want.kind), 64'(rsp_out_kind));
            check_field("out_queue", 64'(want.queue), 64'(rsp_out_queue));
            check_field("slot_index", 64'(want.slot), 64'(rsp_slot_index));
            check_field("dword_index", 64'(want.dw), 64'(rsp_dword_index));
            check_field("write_data", 64'(want.data), 64'(rsp_write_data));
            check_field("doorbell_offset", 64'(want.dboff), 64'(rsp_doorbell_offset));
            check_field("command_id", 64'(want.cid), 64'(rsp_command_id));
            check_field("completion_state", 64'(want.cstate), 64'(rsp_completion_state));
            check_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
   end

   // Hang detection: any run of cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cnt = 0;
      end else begin
         idle_cnt = idle_cnt + 1;
         if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("nvme_host_queue_pair_engine_top regression: fail");
            $finish;
         end
      end
   end

endmodule

// File: files.f
design/nhqp_pkg.sv
design/nhqp_front.sv
design/nhqp_queue.sv
design/nhqp_back.sv
design/nvme_host_queue_pair_engine_top.sv
sim/tb_nvme_host_queue_pair_engine_top.sv
